// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/core/tdic_pkg.sv =====
`timescale 1ns / 1ps

package tdic_pkg;

   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_READ    = 3'd1;
   localparam logic [2:0] OP_WRITE   = 3'd2;
   localparam logic [2:0] OP_SERVICE = 3'd3;
   localparam logic [2:0] OP_RAISE   = 3'd4;

   localparam logic [2:0] REG_DIV  = 3'd0;
   localparam logic [2:0] REG_TIMA = 3'd1;
   localparam logic [2:0] REG_TMA  = 3'd2;
   localparam logic [2:0] REG_TAC  = 3'd3;
   localparam logic [2:0] REG_IF   = 3'd4;
   localparam logic [2:0] REG_IE   = 3'd5;

   localparam int unsigned NUM_SOURCES = 5;
   localparam logic [6:0] IRQ_VEC_BASE    = 7'h40;
   localparam logic [7:0] TIMER_IRQ_BIT   = 8'h04;
   localparam logic [7:0] BYTE_MAX        = 8'hFF;
   localparam logic [4:0] SHIFT_RESET     = 5'd12;
   localparam logic [5:0] TAC_ENABLE_HIGH = 6'd1;

   typedef struct packed {
      logic       taken;
      logic [2:0] src;
   } irq_pick_type;

endpackage

// ===== rtl/core/timer_divider_interrupt_controller_top.sv =====
`timescale 1ns / 1ps

// Timer, divider and interrupt controller of an emulated handheld console.
// req_ channel: one word per item (operation, reg_select, write_value,
// request_mask, master_enable). Tick items advance the free-running count,
// DIV and TIMA; read/write items reach DIV, TIMA, TMA, TAC, IF and IE; raise
// items OR request lines into IF; service items dispatch the lowest pending
// enabled source when master_enable is set.
// rsp_ channel: exactly one result word per item, in order.
// csr_ channel: writes timer_shift; csr_ready is always high. Write it only
// while no item is in flight.
// An accepted word is registered in the input stage; its result is loaded into the
// output register when the output stage can advance, and rsp_valid rises with it.
// Throughput is one item per cycle while the output is not stalled: each item is
// a single pass of small logic on the state registers.
// Reset (synchronous, active high) clears the count, timer and interrupt registers,
// empties both stages and sets timer_shift to 12. No clearing pass is needed.
// When rsp_stall is high the output word holds; an empty input stage still takes
// one more word, then req_stall rises until the output is taken.
module timer_divider_interrupt_controller_top #(
   parameter int unsigned COUNT_BITS = 18
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_operation,
   input  logic [2:0] req_reg_select,
   input  logic [7:0] req_write_value,
   input  logic [4:0] req_request_mask,
   input  logic       req_master_enable,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_value,
   output logic       rsp_irq_taken,
   output logic [2:0] rsp_irq_source,
   output logic [6:0] rsp_irq_vector,
   output logic       rsp_clear_master,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_timer_shift
);

   logic [4:0] timer_shift_ff;

   logic       s1_valid_ff, s1_valid_in;
   logic [2:0] s1_op_ff, s1_sel_ff;
   logic [7:0] s1_wv_ff;
   logic [4:0] s1_req_ff;
   logic       s1_ime_ff;

   logic [COUNT_BITS-1:0] tick_ff, tick_in;
   logic [7:0] div_ff, div_in, div_last_ff, div_last_in;
   logic [7:0] tima_ff, tima_in, tma_ff, tma_in, tac_ff, tac_in;
   logic [7:0] if_ff, if_in, ie_ff, ie_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rd_ff, rd_in;
   logic       taken_ff, taken_in;
   logic [2:0] src_ff, src_in;
   logic [6:0] vec_ff, vec_in;
   logic       clr_ff, clr_in;

   logic       advance, s1_fire;
   logic [COUNT_BITS-1:0] tmask;
   tdic_pkg::irq_pick_type pick;

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign s1_fire   = s1_valid_ff && advance;
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   // A shift at or beyond the count width gives an all-ones mask.
   assign tmask = ~({COUNT_BITS{1'b1}} << timer_shift_ff);

   tdic_irq_arb u_arb (
      .clock   (clock),
      .reset   (reset),
      .pending (if_ff[4:0] & ie_ff[4:0]),
      .pick    (pick)
   );

   always_comb begin
      tick_in     = tick_ff;
      div_in      = div_ff;
      div_last_in = div_last_ff;
      tima_in     = tima_ff;
      tma_in      = tma_ff;
      tac_in      = tac_ff;
      if_in       = if_ff;
      ie_in       = ie_ff;
      rd_in       = 8'd0;
      taken_in    = 1'b0;
      src_in      = 3'd0;
      vec_in      = 7'd0;
      clr_in      = 1'b0;
      case (s1_op_ff)
         tdic_pkg::OP_TICK: begin
            // A DIV that no longer matches its last stepped value was written.
            if (div_ff != div_last_ff) begin
               div_in = 8'd0;
            end
            if (tick_ff[7:0] == 8'd0) begin
               div_in      = div_ff + 8'd1;
               div_last_in = div_ff + 8'd1;
            end
            if (tac_ff[7:2] == tdic_pkg::TAC_ENABLE_HIGH &&
                (tick_ff & tmask) == '0) begin
               if (tima_ff == tdic_pkg::BYTE_MAX) begin
                  tima_in = tma_ff;
                  if_in   = if_ff | tdic_pkg::TIMER_IRQ_BIT;
               end else begin
                  tima_in = tima_ff + 8'd1;
               end
            end
            tick_in = tick_ff + {{(COUNT_BITS-1){1'b0}}, 1'b1};
         end
         tdic_pkg::OP_READ: begin
            case (s1_sel_ff)
               tdic_pkg::REG_DIV:  rd_in = div_ff;
               tdic_pkg::REG_TIMA: rd_in = tima_ff;
               tdic_pkg::REG_TMA:  rd_in = tma_ff;
               tdic_pkg::REG_TAC:  rd_in = tac_ff;
               tdic_pkg::REG_IF:   rd_in = if_ff;
               tdic_pkg::REG_IE:   rd_in = ie_ff;
               default:            rd_in = 8'd0;
            endcase
         end
         tdic_pkg::OP_WRITE: begin
            case (s1_sel_ff)
               tdic_pkg::REG_DIV:  div_in  = s1_wv_ff;
               tdic_pkg::REG_TIMA: tima_in = s1_wv_ff;
               tdic_pkg::REG_TMA:  tma_in  = s1_wv_ff;
               tdic_pkg::REG_TAC:  tac_in  = s1_wv_ff;
               tdic_pkg::REG_IF:   if_in   = s1_wv_ff;
               tdic_pkg::REG_IE:   ie_in   = s1_wv_ff;
               default: ;
            endcase
         end
         tdic_pkg::OP_SERVICE: begin
            if (s1_ime_ff && pick.taken) begin
               if_in    = if_ff & ~(8'd1 << pick.src);
               taken_in = 1'b1;
               src_in   = pick.src;
               vec_in   = tdic_pkg::IRQ_VEC_BASE | {1'b0, pick.src, 3'b000};
               clr_in   = 1'b1;
            end
         end
         tdic_pkg::OP_RAISE: begin
            if_in = if_ff | {3'b000, s1_req_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_shift_ff <= tdic_pkg::SHIFT_RESET;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         tick_ff        <= '0;
         div_ff         <= 8'd0;
         div_last_ff    <= 8'd0;
         tima_ff        <= 8'd0;
         tma_ff         <= 8'd0;
         tac_ff         <= 8'd0;
         if_ff          <= 8'd0;
         ie_ff          <= 8'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            timer_shift_ff <= csr_timer_shift;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            tick_ff     <= tick_in;
            div_ff      <= div_in;
            div_last_ff <= div_last_in;
            tima_ff     <= tima_in;
            tma_ff      <= tma_in;
            tac_ff      <= tac_in;
            if_ff       <= if_in;
            ie_ff       <= ie_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_op_ff  <= req_operation;
         s1_sel_ff <= req_reg_select;
         s1_wv_ff  <= req_write_value;
         s1_req_ff <= req_request_mask;
         s1_ime_ff <= req_master_enable;
      end
      if (s1_fire) begin
         rd_ff    <= rd_in;
         taken_ff <= taken_in;
         src_ff   <= src_in;
         vec_ff   <= vec_in;
         clr_ff   <= clr_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rd_ff;
   assign rsp_irq_taken    = taken_ff;
   assign rsp_irq_source   = src_ff;
   assign rsp_irq_vector   = vec_ff;
   assign rsp_clear_master = clr_ff;

   `ASSERT_IMP(a_taken_word, clock, reset, rsp_valid_ff && taken_ff,
      clr_ff && rd_ff == 8'd0 && vec_ff[6] && src_ff <= 3'd4)
   `ASSERT_IMP(a_idle_word, clock, reset, rsp_valid_ff && !taken_ff,
      !clr_ff && src_ff == 3'd0 && vec_ff == 7'd0)
   `ASSERT_IMP(a_stall_full, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff)
   `ASSERT_NXT(a_service_clears, clock, reset,
      s1_fire && s1_op_ff == tdic_pkg::OP_SERVICE && taken_in,
      !if_ff[src_ff] && rsp_valid_ff)

endmodule

// ===== rtl/core/tdic_irq_arb.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tdic_irq_arb (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [4:0]            pending,
   output tdic_pkg::irq_pick_type pick
);

   // Lowest numbered pending source wins.
   always_comb begin
      pick.taken = |pending;
      pick.src   = 3'd0;
      for (int n = tdic_pkg::NUM_SOURCES - 1; n >= 0; n--) begin
         if (pending[n]) begin
            pick.src = 3'(n);
         end
      end
   end

   `ASSERT_IMP(a_pick_pending, clock, reset, pick.taken, pending[pick.src])
   `ASSERT_IMP(a_pick_lowest, clock, reset, pick.taken,
      ((pending & ((5'd1 << pick.src) - 5'd1)) == 5'd0))

endmodule

// ===== verif/tdic_response_check.sv =====
`timescale 1ns / 1ps

module tdic_response_check #(
   parameter int unsigned COUNT_BITS = 18
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [2:0] req_operation,
   input  logic [2:0] req_reg_select,
   input  logic [7:0] req_write_value,
   input  logic [4:0] req_request_mask,
   input  logic       req_master_enable,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_read_value,
   input  logic       rsp_irq_taken,
   input  logic [2:0] rsp_irq_source,
   input  logic [6:0] rsp_irq_vector,
   input  logic       rsp_clear_master,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [4:0] csr_timer_shift,
   output int         fault_count,
   output int         in_flight
);

   typedef struct packed {
      logic [7:0] read_value;
      logic       irq_taken;
      logic [2:0] irq_source;
      logic [6:0] irq_vector;
      logic       clear_master;
   } reply_type;

   reply_type due_replies[$];

   logic [COUNT_BITS-1:0] tick_count;
   logic [4:0] timer_shift;
   logic [7:0] div_value;
   logic [7:0] div_last;
   logic [7:0] tima_value;
   logic [7:0] tma_value;
   logic [7:0] tac_value;
   logic [7:0] int_flags;
   logic [7:0] int_enables;

   initial begin
      fault_count = 0;
      in_flight   = 0;
   end

   // Advances the controller state by one word and returns the reply it owes.
   function automatic reply_type apply_word(input logic [2:0] op, input logic [2:0] sel,
                                            input logic [7:0] wv, input logic [4:0] mask,
                                            input logic ime);
      reply_type reply;
      logic [7:0] div_before;
      logic [63:0] span_mask;
      logic [4:0] pend;
      reply = '0;
      case (op)
         tdic_pkg::OP_TICK: begin
            // a DIV that no longer matches its last step was written: clear it
            div_before = div_value;
            if (div_before != div_last)
               div_value = 8'h00;
            if (tick_count[7:0] == 8'h00) begin
               div_value = div_before + 8'd1;
               div_last  = div_value;
            end
            if (tac_value[7:2] == tdic_pkg::TAC_ENABLE_HIGH) begin
               // shifts at or past the count width only fire on a zero count
               span_mask = (64'd1 << timer_shift) - 64'd1;
               if ((64'(tick_count) & span_mask) == 64'd0) begin
                  if (tima_value == tdic_pkg::BYTE_MAX) begin
                     int_flags  = int_flags | tdic_pkg::TIMER_IRQ_BIT;
                     tima_value = tma_value;
                  end else begin
                     tima_value = tima_value + 8'd1;
                  end
               end
            end
            tick_count = tick_count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
         end
         tdic_pkg::OP_READ: begin
            case (sel)
               tdic_pkg::REG_DIV:  reply.read_value = div_value;
               tdic_pkg::REG_TIMA: reply.read_value = tima_value;
               tdic_pkg::REG_TMA:  reply.read_value = tma_value;
               tdic_pkg::REG_TAC:  reply.read_value = tac_value;
               tdic_pkg::REG_IF:   reply.read_value = int_flags;
               tdic_pkg::REG_IE:   reply.read_value = int_enables;
               default:            reply.read_value = 8'h00;
            endcase
         end
         tdic_pkg::OP_WRITE: begin
            case (sel)
               tdic_pkg::REG_DIV:  div_value   = wv;
               tdic_pkg::REG_TIMA: tima_value  = wv;
               tdic_pkg::REG_TMA:  tma_value   = wv;
               tdic_pkg::REG_TAC:  tac_value   = wv;
               tdic_pkg::REG_IF:   int_flags   = wv;
               tdic_pkg::REG_IE:   int_enables = wv;
               default: ;
            endcase
         end
         tdic_pkg::OP_SERVICE: begin
            if (ime) begin
               pend = int_flags[4:0] & int_enables[4:0];
               for (int n = 0; n < tdic_pkg::NUM_SOURCES; n++) begin
                  if (!reply.irq_taken && pend[n]) begin
                     int_flags[n]       = 1'b0;
                     reply.irq_taken    = 1'b1;
                     reply.irq_source   = 3'(n);
                     reply.irq_vector   = tdic_pkg::IRQ_VEC_BASE + 7'(8 * n);
                     reply.clear_master = 1'b1;
                  end
               end
            end
         end
         tdic_pkg::OP_RAISE: int_flags = int_flags | {3'b000, mask};
         default: ;
      endcase
      return reply;
   endfunction

   task automatic compare_reply(input reply_type want, input reply_type got);
      if (got.read_value !== want.read_value) begin
         $error("read_value expected %0h got %0h", want.read_value, got.read_value);
         fault_count++;
      end
      if (got.irq_taken !== want.irq_taken) begin
         $error("irq_taken expected %0h got %0h", want.irq_taken, got.irq_taken);
         fault_count++;
      end
      if (got.irq_source !== want.irq_source) begin
         $error("irq_source expected %0h got %0h", want.irq_source, got.irq_source);
         fault_count++;
      end
      if (got.irq_vector !== want.irq_vector) begin
         $error("irq_vector expected %0h got %0h", want.irq_vector, got.irq_vector);
         fault_count++;
      end
      if (got.clear_master !== want.clear_master) begin
         $error("clear_master expected %0h got %0h", want.clear_master, got.clear_master);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      reply_type got;
      if (reset) begin
         due_replies.delete();
         tick_count  = '0;
         timer_shift = tdic_pkg::SHIFT_RESET;
         div_value   = 8'h00;
         div_last    = 8'h00;
         tima_value  = 8'h00;
         tma_value   = 8'h00;
         tac_value   = 8'h00;
         int_flags   = 8'h00;
         int_enables = 8'h00;
      end else begin
         // retire first: a word taken on this edge cannot answer itself
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_read_value, rsp_irq_taken, rsp_irq_source, rsp_irq_vector,
                   rsp_clear_master};
            if (due_replies.size() == 0) begin
               $error("reply word with nothing outstanding");
               fault_count++;
            end else begin
               compare_reply(due_replies.pop_front(), got);
            end
         end
         if (csr_valid && csr_ready)
            timer_shift = csr_timer_shift;
         if (req_valid && !req_stall)
            due_replies.push_back(apply_word(req_operation, req_reg_select, req_write_value,
                                             req_request_mask, req_master_enable));
      end
      in_flight = due_replies.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned COUNT_BITS = 18;
   localparam logic [2:0] OP_UNUSED_TOP  = 3'd7;
   localparam logic [2:0] REG_UNUSED_TOP = 3'd7;
   localparam int unsigned PHASES = 8;
   localparam int unsigned WORDS_PER_PHASE = 190;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_operation = tdic_pkg::OP_TICK;
   logic [2:0] req_reg_select = tdic_pkg::REG_DIV;
   logic [7:0] req_write_value = 8'h00;
   logic [4:0] req_request_mask = 5'h00;
   logic       req_master_enable = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_value;
   logic       rsp_irq_taken;
   logic [2:0] rsp_irq_source;
   logic [6:0] rsp_irq_vector;
   logic       rsp_clear_master;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [4:0] csr_timer_shift = tdic_pkg::SHIFT_RESET;

   int fault_count;
   int in_flight;
   int send_idle_pct = 0;
   int stall_pct = 0;

   // a spread of shifts from 0 up to 31, including the count width of 18
   logic [4:0] shift_plan [PHASES] = '{5'd1, 5'd18, 5'd0, 5'd31, 5'd2, 5'd13, 5'd3, 5'd12};

   always #6 clock = ~clock;

   timer_divider_interrupt_controller_top #(
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_reg_select   (req_reg_select),
      .req_write_value  (req_write_value),
      .req_request_mask (req_request_mask),
      .req_master_enable(req_master_enable),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_value   (rsp_read_value),
      .rsp_irq_taken    (rsp_irq_taken),
      .rsp_irq_source   (rsp_irq_source),
      .rsp_irq_vector   (rsp_irq_vector),
      .rsp_clear_master (rsp_clear_master),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_timer_shift  (csr_timer_shift)
   );

   tdic_response_check #(
      .COUNT_BITS(COUNT_BITS)
   ) response_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_reg_select   (req_reg_select),
      .req_write_value  (req_write_value),
      .req_request_mask (req_request_mask),
      .req_master_enable(req_master_enable),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_value   (rsp_read_value),
      .rsp_irq_taken    (rsp_irq_taken),
      .rsp_irq_source   (rsp_irq_source),
      .rsp_irq_vector   (rsp_irq_vector),
      .rsp_clear_master (rsp_clear_master),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_timer_shift  (csr_timer_shift),
      .fault_count      (fault_count),
      .in_flight        (in_flight)
   );

   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // Entered and left just after a falling edge.
   task automatic send_word(input logic [2:0] op, input logic [2:0] sel,
                            input logic [7:0] wv, input logic [4:0] mask,
                            input logic ime);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_reg_select    <= sel;
      req_write_value   <= wv;
      req_request_mask  <= mask;
      req_master_enable <= ime;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_timer_shift(input logic [4:0] shift);
      csr_valid       <= 1'b1;
      csr_timer_shift <= shift;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stops sending, then a bounded wait for every outstanding reply.
   task automatic drain_replies();
      req_valid <= 1'b0;
      for (int spin = 0; spin < 20000 && in_flight != 0; spin++)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned roll;
      logic [2:0] op;
      logic [2:0] sel;
      logic [7:0] wv;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // shift 0 steps TIMA on every enabled tick
      write_timer_shift(5'd0);
      // upper TAC bits keep the timer off
      send_word(tdic_pkg::OP_WRITE, tdic_pkg::REG_TAC, tdic_pkg::BYTE_MAX, 5'h00, 1'b0);
      send_word(tdic_pkg::OP_READ, tdic_pkg::REG_TAC, 8'h00, 5'h00, 1'b0);
      send_word(tdic_pkg::OP_TICK, tdic_pkg::REG_DIV, 8'h00, 5'h00, 1'b0);
      send_word(tdic_pkg::OP_WRITE, tdic_pkg::REG_TMA, 8'hA5, 5'h00, 1'b0);
      send_word(tdic_pkg::OP_WRITE, tdic_pkg::REG_TIMA, tdic_pkg::BYTE_MAX, 5'h00, 1'b0);
      send_word(tdic_pkg::OP_WRITE, tdic_pkg::REG_TAC, 8'h05, 5'h00, 1'b0);
      // overflow, reload, timer flag
      send_word(tdic_pkg::OP_TICK, tdic_pkg::REG_DIV, 8'h00, 5'h00, 1'b0);
      send_word(tdic_pkg::OP_READ, tdic_pkg::REG_TIMA, 8'h00, 5'h00, 1'b0);
      send_word(tdic_pkg::OP_READ, tdic_pkg::REG_IF, 8'h00, 5'h00, 1'b0);
      send_word(tdic_pkg::OP_WRITE, tdic_pkg::REG_IE, tdic_pkg::BYTE_MAX, 5'h00, 1'b0);
      send_word(tdic_pkg::OP_READ, tdic_pkg::REG_IE, 8'h00, 5'h00, 1'b0);
      // master enable off
      send_word(tdic_pkg::OP_SERVICE, tdic_pkg::REG_DIV, 8'h00, 5'h00, 1'b0);
      send_word(tdic_pkg::OP_SERVICE, tdic_pkg::REG_DIV, 8'h00, 5'h00, 1'b1);
      send_word(tdic_pkg::OP_RAISE, tdic_pkg::REG_DIV, 8'h00, 5'h1F, 1'b0);
      // last one finds nothing
      for (int n = 0; n <= tdic_pkg::NUM_SOURCES; n++)
         send_word(tdic_pkg::OP_SERVICE, tdic_pkg::REG_DIV, 8'h00, 5'h00, 1'b1);
      send_word(tdic_pkg::OP_WRITE, tdic_pkg::REG_DIV, 8'h3C, 5'h00, 1'b0);
      // written DIV gets cleared
      send_word(tdic_pkg::OP_TICK, tdic_pkg::REG_DIV, 8'h00, 5'h00, 1'b0);
      send_word(tdic_pkg::OP_READ, tdic_pkg::REG_DIV, 8'h00, 5'h00, 1'b0);
      send_word(tdic_pkg::OP_READ, REG_UNUSED_TOP - 3'd1, 8'h00, 5'h00, 1'b0);
      send_word(tdic_pkg::OP_WRITE, REG_UNUSED_TOP, tdic_pkg::BYTE_MAX, 5'h1F, 1'b1);
      send_word(OP_UNUSED_TOP, REG_UNUSED_TOP, tdic_pkg::BYTE_MAX, 5'h1F, 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 67; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 67; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         drain_replies();
         write_timer_shift(shift_plan[phase]);
         send_word(tdic_pkg::OP_WRITE, tdic_pkg::REG_TAC,
                   {tdic_pkg::TAC_ENABLE_HIGH, 2'($urandom_range(3))}, 5'h00, 1'b0);
         repeat (WORDS_PER_PHASE) begin
            roll = $urandom_range(99);
            if (roll < 50)
               op = tdic_pkg::OP_TICK;
            else if (roll < 63)
               op = tdic_pkg::OP_READ;
            else if (roll < 78)
               op = tdic_pkg::OP_WRITE;
            else if (roll < 89)
               op = tdic_pkg::OP_SERVICE;
            else if (roll < 96)
               op = tdic_pkg::OP_RAISE;
            else
               op = 3'($urandom_range(tdic_pkg::OP_RAISE + 1, OP_UNUSED_TOP));
            if ($urandom_range(9) == 0)
               sel = 3'($urandom_range(tdic_pkg::REG_IE + 1, REG_UNUSED_TOP));
            else
               sel = 3'($urandom_range(tdic_pkg::REG_IE));
            wv = 8'($urandom_range(tdic_pkg::BYTE_MAX));
            // keep the timer running most of the time and TIMA near overflow
            if (op == tdic_pkg::OP_WRITE && sel == tdic_pkg::REG_TAC &&
                $urandom_range(4) != 0)
               wv = {tdic_pkg::TAC_ENABLE_HIGH, 2'($urandom_range(3))};
            if (op == tdic_pkg::OP_WRITE && sel == tdic_pkg::REG_TIMA &&
                $urandom_range(1) == 1)
               wv = 8'($urandom_range(8'hF0, tdic_pkg::BYTE_MAX));
            send_word(op, sel, wv, 5'($urandom), $urandom_range(9) < 8);
         end
      end

      drain_replies();
      if (fault_count == 0 && in_flight == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
